>>> hdl/rfalu_pkg.sv
// Shared types, codes and defaults for the register file ALU executor.
`default_nettype none

package rfalu_pkg;

    localparam int NUM_REGS_DEF   = 10;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FUNC_W         = 4;
    localparam int REG_IDX_W      = 4;
    localparam int VALUE_W        = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD  = 4'd0,
        FUNC_SUB  = 4'd1,
        FUNC_DIV  = 4'd2,
        FUNC_MUL  = 4'd3,
        FUNC_MOVE = 4'd4,
        FUNC_LDI  = 4'd5,
        FUNC_AND  = 4'd6,
        FUNC_OR   = 4'd7,
        FUNC_NOT  = 4'd8,
        FUNC_MAX  = 4'd9
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_DIV_ZERO = 2'd1,
        STATUS_BAD_REG  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ITER,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic [REG_IDX_W-1:0]      dest_reg;
        logic [REG_IDX_W-1:0]      src_reg;
        logic signed [VALUE_W-1:0] immediate;
    } instr_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic                      is_report;
        logic [1:0]                status;
    } result_t;

    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic needs_iter;
        logic iter_done;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hdl/rfalu_dp.sv
// Datapath: register file, operand decode, shift-add / restoring iteration unit, result register.
`default_nettype none

module rfalu_dp #(
    parameter int NUM_REGS   = rfalu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire rfalu_pkg::ctl_cmd_t  ctl,
    input  wire rfalu_pkg::instr_t    instr,
    output rfalu_pkg::dp_stat_t       stat,
    output rfalu_pkg::result_t        result
);

    localparam int IDX_W = $clog2(NUM_REGS);
    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam int CMP_W = rfalu_pkg::REG_IDX_W + 1;

    logic [DATA_WIDTH-1:0] regfile_mem [NUM_REGS];
    logic [NUM_REGS-1:0]   valid_reg;

    rfalu_pkg::instr_t     instr_reg;
    logic [DATA_WIDTH-1:0] a_raw_reg;
    logic [DATA_WIDTH-1:0] b_raw_reg;
    logic                  a_vld_reg;
    logic                  b_vld_reg;

    logic [DATA_WIDTH-1:0] acc_reg, acc_next;
    logic [DATA_WIDTH-1:0] x_reg, x_next;
    logic [DATA_WIDTH-1:0] y_reg, y_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    rfalu_pkg::result_t    result_reg;

    logic                  dest_bad;
    logic                  src_bad;
    logic                  needs_src;
    logic                  known_func;
    logic                  bad_idx;
    logic                  div_zero;
    logic                  is_mul;
    logic [DATA_WIDTH-1:0] a;
    logic [DATA_WIDTH-1:0] b;
    logic [DATA_WIDTH-1:0] a_mag;
    logic [DATA_WIDTH-1:0] b_mag;
    logic [DATA_WIDTH-1:0] quo;
    logic [DATA_WIDTH:0]   rem_sh;
    logic [DATA_WIDTH:0]   rem_diff;
    logic                  rem_ge;
    logic [DATA_WIDTH-1:0] value;
    logic                  report;
    rfalu_pkg::status_t    status;
    logic                  write;
    logic                  wr_en;
    logic [IDX_W-1:0]      dest_idx;

    // operand decode
    always_comb
    begin
        dest_bad   = {1'b0, instr_reg.dest_reg} >= CMP_W'(NUM_REGS);
        src_bad    = {1'b0, instr_reg.src_reg} >= CMP_W'(NUM_REGS);
        needs_src  = (instr_reg.func != rfalu_pkg::FUNC_LDI)
                  && (instr_reg.func != rfalu_pkg::FUNC_NOT);
        known_func = instr_reg.func inside {[rfalu_pkg::FUNC_ADD:rfalu_pkg::FUNC_MAX]};
        bad_idx    = known_func && (dest_bad || (needs_src && src_bad));
        a          = a_vld_reg ? a_raw_reg : '0;
        b          = (needs_src && b_vld_reg) ? b_raw_reg : '0;
        a_mag      = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
        b_mag      = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
        div_zero   = (b == '0);
        is_mul     = (instr_reg.func == rfalu_pkg::FUNC_MUL);
        dest_idx   = instr_reg.dest_reg[IDX_W-1:0];

        stat.needs_iter = !bad_idx && (is_mul
                       || ((instr_reg.func == rfalu_pkg::FUNC_DIV) && !div_zero));
        stat.iter_done  = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    end

    // one bit per step: shift-add multiply, or restoring divide on magnitudes
    always_comb
    begin
        rem_sh   = {acc_reg, y_reg[DATA_WIDTH-1]};
        rem_ge   = rem_sh >= {1'b0, x_reg};
        rem_diff = rem_sh - {1'b0, x_reg};
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        cnt_next = cnt_reg;
        if (ctl.start)
        begin
            cnt_next = '0;
            acc_next = '0;
            if (is_mul)
            begin
                x_next = a;
                y_next = b;
            end
            else
            begin
                x_next = b_mag;
                y_next = a_mag;
            end
        end
        else if (ctl.step)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (is_mul)
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = x_reg << 1;
                y_next = y_reg >> 1;
            end
            else if (rem_ge)
            begin
                acc_next = rem_diff[DATA_WIDTH-1:0];
                y_next   = {y_reg[DATA_WIDTH-2:0], 1'b1};
            end
            else
            begin
                acc_next = rem_sh[DATA_WIDTH-1:0];
                y_next   = {y_reg[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    // result and writeback
    always_comb
    begin
        quo    = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? (~y_reg + 1'b1) : y_reg;
        value  = '0;
        report = 1'b0;
        status = rfalu_pkg::STATUS_OK;
        write  = 1'b0;
        if (bad_idx)
        begin
            status = rfalu_pkg::STATUS_BAD_REG;
        end
        else
        begin
            case (instr_reg.func)
                rfalu_pkg::FUNC_ADD:
                begin
                    value = a + b;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_SUB:
                begin
                    value = a - b;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_DIV:
                begin
                    if (div_zero)
                    begin
                        status = rfalu_pkg::STATUS_DIV_ZERO;
                    end
                    else
                    begin
                        value = quo;
                        write = 1'b1;
                    end
                end
                rfalu_pkg::FUNC_MUL:
                begin
                    value = acc_reg;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_MOVE:
                begin
                    value = b;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_LDI:
                begin
                    value = DATA_WIDTH'($signed(instr_reg.immediate));
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_AND:
                begin
                    value = a & b;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_OR:
                begin
                    value = a | b;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_NOT:
                begin
                    value = ~a;
                    write = 1'b1;
                end
                rfalu_pkg::FUNC_MAX:
                begin
                    value  = ($signed(a) > $signed(b)) ? a : b;
                    report = 1'b1;
                end
                default:
                begin
                    value = '0;
                end
            endcase
        end
        wr_en = ctl.finish && write;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            instr_reg <= instr;
            a_raw_reg <= regfile_mem[instr.dest_reg[IDX_W-1:0]];
            b_raw_reg <= regfile_mem[instr.src_reg[IDX_W-1:0]];
            a_vld_reg <= valid_reg[instr.dest_reg[IDX_W-1:0]];
            b_vld_reg <= valid_reg[instr.src_reg[IDX_W-1:0]];
        end
        if (wr_en)
        begin
            regfile_mem[dest_idx] <= value;
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
            begin
                valid_reg[dest_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (ctl.finish)
        begin
            result_reg.result_value <= rfalu_pkg::VALUE_W'(value);
            result_reg.is_report    <= report;
            result_reg.status       <= status;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> hdl/rfalu_ctrl.sv
// Controller: sequences capture, decode, iteration and finish for one instruction at a time.
`default_nettype none

module rfalu_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output logic                     cmd_stall,
    output logic                     rsp_valid,
    input  wire logic                rsp_stall,
    input  wire rfalu_pkg::dp_stat_t stat,
    output rfalu_pkg::ctl_cmd_t      ctl
);

    rfalu_pkg::state_t state_reg, state_next;
    logic              rsp_valid_reg, rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rfalu_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd_stall      = (state_reg != rfalu_pkg::ST_IDLE);
        case (state_reg)
            rfalu_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    state_next  = rfalu_pkg::ST_DECODE;
                end
            end
            rfalu_pkg::ST_DECODE:
            begin
                if (stat.needs_iter)
                begin
                    ctl.start  = 1'b1;
                    state_next = rfalu_pkg::ST_ITER;
                end
                else
                begin
                    state_next = rfalu_pkg::ST_FINISH;
                end
            end
            rfalu_pkg::ST_ITER:
            begin
                ctl.step = 1'b1;
                if (stat.iter_done)
                begin
                    state_next = rfalu_pkg::ST_FINISH;
                end
            end
            rfalu_pkg::ST_FINISH:
            begin
                // hold until the output slot is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctl.finish     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = rfalu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rfalu_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

`default_nettype wire

>>> hdl/register_file_alu_executor_unit.sv
// The result register is loaded in the finish state: most ops go from capture through
// decode to finish, while mul and div with a nonzero divisor also pass the iteration state.
// Only one instruction is in flight at a time; mul/div use the one-bit-per-cycle
// shift-add / restoring divide unit.
// A new instruction is taken while the previous result waits in the output register.
// Reset: asynchronous, active low; registers read as zero through per-entry valid bits.
`default_nettype none

module register_file_alu_executor_unit #(
    parameter int NUM_REGS   = rfalu_pkg::NUM_REGS_DEF,
    parameter int DATA_WIDTH = rfalu_pkg::DATA_WIDTH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire rfalu_pkg::instr_t  cmd,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output rfalu_pkg::result_t      rsp
);

    rfalu_pkg::ctl_cmd_t ctl_cmd;
    rfalu_pkg::dp_stat_t dp_stat;

    rfalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (dp_stat),
        .ctl       (ctl_cmd)
    );

    rfalu_dp #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl_cmd),
        .instr  (cmd),
        .stat   (dp_stat),
        .result (rsp)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second transfer taken while an instruction is in flight");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.finish |=> rsp_valid)
        else $error("finished result not presented");

    a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.finish |=> !cmd_stall)
        else $error("input not reopened after finish");

    a_capture_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_cmd.capture |-> !cmd_stall && !ctl_cmd.step && !ctl_cmd.finish)
        else $error("capture outside idle");

endmodule

`default_nettype wire

>>> verif/register_file_alu_executor_unit_test.sv
// Self-checking testbench for the register file ALU executor, checked against a shadow file.
`timescale 1ns / 100ps

module register_file_alu_executor_unit_test;

    localparam int NUM_REGS     = rfalu_pkg::NUM_REGS_DEF;
    localparam int DATA_WIDTH   = rfalu_pkg::DATA_WIDTH_DEF;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = DATA_WIDTH + 20;
    localparam int MAX_REG_IDX  = (1 << rfalu_pkg::REG_IDX_W) - 1;
    localparam logic [rfalu_pkg::FUNC_W-1:0] FUNC_UNUSED_LO = 4'd10;
    localparam logic [rfalu_pkg::FUNC_W-1:0] FUNC_UNUSED_HI = 4'd15;

    class regfile_shadow;
        logic [rfalu_pkg::VALUE_W-1:0] regs [NUM_REGS];
        rfalu_pkg::result_t            pending_results [$];
        int                            errors;
        int                            n_checked;
        int                            n_report;
        int                            n_div_zero;
        int                            n_bad_reg;

        function new();
            foreach (regs[k])
                regs[k] = '0;
            errors     = 0;
            n_checked  = 0;
            n_report   = 0;
            n_div_zero = 0;
            n_bad_reg  = 0;
        endfunction

        function void execute(rfalu_pkg::instr_t i);
            rfalu_pkg::result_t            e;
            logic [rfalu_pkg::VALUE_W-1:0] a;
            logic [rfalu_pkg::VALUE_W-1:0] b;
            logic [rfalu_pkg::VALUE_W-1:0] v;
            logic                          wr;
            logic                          needs_src;
            longint                        qa;
            longint                        qb;
            e = '0;
            v = '0;
            needs_src = !(i.func == rfalu_pkg::FUNC_LDI || i.func == rfalu_pkg::FUNC_NOT);
            if (i.func inside {[rfalu_pkg::FUNC_ADD:rfalu_pkg::FUNC_MAX]})
            begin
                if (i.dest_reg >= NUM_REGS || (needs_src && i.src_reg >= NUM_REGS))
                begin
                    e.status = rfalu_pkg::STATUS_BAD_REG;
                end
                else
                begin
                    a  = regs[i.dest_reg];
                    b  = needs_src ? regs[i.src_reg] : '0;
                    wr = 1'b1;
                    case (rfalu_pkg::func_t'(i.func))
                        rfalu_pkg::FUNC_ADD:  v = a + b;
                        rfalu_pkg::FUNC_SUB:  v = a - b;
                        rfalu_pkg::FUNC_DIV:
                        begin
                            if (b == '0)
                            begin
                                e.status = rfalu_pkg::STATUS_DIV_ZERO;
                                wr = 1'b0;
                            end
                            else
                            begin
                                qa = longint'($signed(a));
                                qb = longint'($signed(b));
                                v  = rfalu_pkg::VALUE_W'(qa / qb);
                            end
                        end
                        rfalu_pkg::FUNC_MUL:  v = a * b;
                        rfalu_pkg::FUNC_MOVE: v = b;
                        rfalu_pkg::FUNC_LDI:  v = i.immediate;
                        rfalu_pkg::FUNC_AND:  v = a & b;
                        rfalu_pkg::FUNC_OR:   v = a | b;
                        rfalu_pkg::FUNC_NOT:  v = ~a;
                        default:
                        begin
                            v = ($signed(a) > $signed(b)) ? a : b;
                            e.is_report = 1'b1;
                            wr = 1'b0;
                        end
                    endcase
                    if (wr)
                        regs[i.dest_reg] = v;
                end
            end
            e.result_value = v;
            pending_results.push_back(e);
        endfunction

        function void compare(rfalu_pkg::result_t r);
            rfalu_pkg::result_t e;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transfer: result_value %h", r.result_value);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            n_checked++;
            if (e.is_report)
                n_report++;
            if (e.status == rfalu_pkg::STATUS_DIV_ZERO)
                n_div_zero++;
            if (e.status == rfalu_pkg::STATUS_BAD_REG)
                n_bad_reg++;
            if (r.result_value !== e.result_value)
            begin
                $error("result_value: expected %h, got %h", e.result_value, r.result_value);
                errors++;
            end
            if (r.is_report !== e.is_report)
            begin
                $error("is_report: expected %0d, got %0d", e.is_report, r.is_report);
                errors++;
            end
            if (r.status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, r.status);
                errors++;
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    rfalu_pkg::instr_t  cmd       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    rfalu_pkg::result_t rsp;

    regfile_shadow shadow;
    bit            no_idle = 1'b0;
    int            n_sent  = 0;

    register_file_alu_executor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [rfalu_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 6))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return '0;
            4:       return rfalu_pkg::VALUE_W'($urandom_range(0, 31)) - 32'd16;
            5:       return rfalu_pkg::VALUE_W'($urandom_range(0, 1000));
            default: return rfalu_pkg::VALUE_W'($urandom());
        endcase
    endfunction

    function automatic rfalu_pkg::instr_t make_instr(logic [rfalu_pkg::FUNC_W-1:0] f,
                                                     int d, int s,
                                                     logic [rfalu_pkg::VALUE_W-1:0] imm);
        rfalu_pkg::instr_t i;
        i.func      = f;
        i.dest_reg  = rfalu_pkg::REG_IDX_W'(d);
        i.src_reg   = rfalu_pkg::REG_IDX_W'(s);
        i.immediate = imm;
        return i;
    endfunction

    function automatic rfalu_pkg::instr_t random_instr();
        rfalu_pkg::instr_t i;
        int                r;
        r = $urandom_range(0, 99);
        i = make_instr(rfalu_pkg::FUNC_W'($urandom_range(rfalu_pkg::FUNC_ADD,
                                                         rfalu_pkg::FUNC_MAX)),
                       $urandom_range(0, NUM_REGS - 1), $urandom_range(0, NUM_REGS - 1),
                       pick_value());
        if (r < 20)
            i.func = rfalu_pkg::FUNC_LDI;
        else if (r >= 88 && r < 93)
            i.func = rfalu_pkg::FUNC_W'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
        else if (r >= 93 && r < 96)
            i.dest_reg = rfalu_pkg::REG_IDX_W'($urandom_range(NUM_REGS, MAX_REG_IDX));
        else if (r >= 96)
            i.src_reg = rfalu_pkg::REG_IDX_W'($urandom_range(NUM_REGS, MAX_REG_IDX));
        return i;
    endfunction

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_instr(rfalu_pkg::instr_t i);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= i;
        do
            @(posedge clk);
        while (cmd_stall);
        shadow.execute(i);
        n_sent++;
    endtask

    initial
    begin
        int hold;
        hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else if (!no_idle && $urandom_range(0, 3) == 0)
                hold = pick_gap() + 1;
            rsp_stall <= (hold > 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            shadow.compare(rsp);
    end

    initial
    begin
        shadow = new();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 0, 0, 32'h7fff_ffff));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 1, 0, 32'h8000_0000));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 2, 0, 32'hffff_ffff));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 4, 0, 32'd7));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 5, 0, -32'sd7));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, 6, 0, 32'd2));
        send_instr(make_instr(rfalu_pkg::FUNC_DIV, 1, 2, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_DIV, 5, 6, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_DIV, 4, 3, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_DIV, 11, 3, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_ADD, 0, 4, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_SUB, 1, 4, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_MUL, 0, 0, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_MOVE, 7, 2, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_AND, 7, 4, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_OR, 8, 5, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_NOT, 9, MAX_REG_IDX, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_MAX, 2, 5, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_MAX, 6, 6, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_ADD, NUM_REGS, 0, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_MAX, 0, MAX_REG_IDX, '0));
        send_instr(make_instr(rfalu_pkg::FUNC_LDI, MAX_REG_IDX, 0, 32'd5));
        send_instr(make_instr(rfalu_pkg::FUNC_NOT, NUM_REGS, 0, '0));
        send_instr(make_instr(FUNC_UNUSED_LO, 0, 0, 32'hffff_ffff));
        send_instr(make_instr(FUNC_UNUSED_HI, MAX_REG_IDX, MAX_REG_IDX, '0));

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            no_idle = ((k / 100) % 4 == 3);
            send_instr(random_instr());
        end
        no_idle = 1'b0;
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (shadow.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d instructions, checked %0d results", n_sent, shadow.n_checked);
        $display("max reports %0d, divide by zero %0d, bad register %0d",
                 shadow.n_report, shadow.n_div_zero, shadow.n_bad_reg);
        if (shadow.errors == 0 && shadow.pending_results.size() == 0)
            $display("register_file_alu_executor_unit_test passed");
        else
            $display("register_file_alu_executor_unit_test failed");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("register_file_alu_executor_unit_test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/rfalu_pkg.sv
hdl/rfalu_dp.sv
hdl/rfalu_ctrl.sv
hdl/register_file_alu_executor_unit.sv
verif/register_file_alu_executor_unit_test.sv
